### rtl/core/sdf_pkg.sv
// Shared types, constants and width helpers of the segment distance field unit.
// Depends on nothing; every other file of the unit imports it.
package sdf_pkg;

  localparam int unsigned PixelCoordBits = 10;
  localparam int unsigned FractionBits   = 4;
  localparam int unsigned MinWidth       = 40;
  localparam int unsigned QueueDepth     = 4;
  localparam int unsigned CountWidth     = 3;
  localparam logic [7:0]  GainReset      = 8'd4;

  typedef enum logic {
    KIND_DIRECT,
    KIND_DIVIDE
  } kind_e;

  typedef struct packed {
    logic [9:0]         pixel_x;
    logic [9:0]         pixel_y;
    logic signed [15:0] seg_start_x;
    logic signed [15:0] seg_start_y;
    logic signed [15:0] seg_end_x;
    logic signed [15:0] seg_end_y;
    logic               last_segment;
  } in_req_t;

  typedef struct packed {
    logic [7:0] distance_code;
  } out_req_t;

  typedef struct packed {
    logic [CountWidth-1:0] count;
    logic                  empty;
  } qstat_t;

  // Width of a coordinate difference in fixed point, sign included.
  function automatic int unsigned diff_width(int unsigned p, int unsigned f);
    int unsigned pf;
    pf = p + f;
    return ((pf > 15) ? pf : 15) + 2;
  endfunction

  // Width of a sum of two products of differences.
  function automatic int unsigned sum_width(int unsigned p, int unsigned f);
    return 2 * diff_width(p, f) + 1;
  endfunction

endpackage

### rtl/core/sdf_in_if.sv
// Request channel carrying one pixel and one segment.
// Depends on sdf_pkg for the payload type.
interface sdf_in_if;
  import sdf_pkg::*;
  logic    valid;
  logic    ready;
  in_req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### rtl/core/sdf_out_if.sv
// Result channel carrying one distance code.
// Depends on sdf_pkg for the payload type.
interface sdf_out_if;
  import sdf_pkg::*;
  logic     valid;
  logic     ready;
  out_req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### rtl/core/sdf_front.sv
// Front end: takes requests, forms differences and products, classifies each pair.
// Depends on sdf_pkg; pushes classified entries into sdf_queue.
module sdf_front #(
  parameter int unsigned PIXEL_COORD_BITS = sdf_pkg::PixelCoordBits,
  parameter int unsigned FRACTION_BITS    = sdf_pkg::FractionBits,
  localparam int unsigned SW = sdf_pkg::sum_width(PIXEL_COORD_BITS, FRACTION_BITS),
  localparam int unsigned EW = 2 * SW + 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sdf_pkg::in_req_t   in_data_i,
  input  sdf_pkg::qstat_t    qstat_i,
  output logic               push_o,
  output logic [EW-1:0]      push_data_o
);
  import sdf_pkg::*;

  localparam int unsigned P  = PIXEL_COORD_BITS;
  localparam int unsigned DW = diff_width(PIXEL_COORD_BITS, FRACTION_BITS);
  localparam int unsigned PW = 2 * DW;

  logic [P+9:0]          pxw, pyw;
  logic signed [DW-1:0]  px, py, x0, y0, x1, y1;
  logic                  accept;

  logic                  v1_q, v2_q;
  logic                  last1_q, last2_q;
  logic signed [DW-1:0]  wx_q, wy_q, vx_q, vy_q, ex_q, ey_q;
  logic signed [PW-1:0]  exwx_q, eywy_q, exex_q, eyey_q, exwy_q, eywx_q;
  logic signed [PW-1:0]  wxwx_q, wywy_q, vxvx_q, vyvy_q;

  logic signed [SW-1:0]  dot, d2, perp;
  logic [SW-1:0]         perp_abs, w2, v2;
  logic [SW-1:0]         value;
  kind_e                 kind;

  assign pxw = (P + 10)'(in_data_i.pixel_x);
  assign pyw = (P + 10)'(in_data_i.pixel_y);
  assign px  = $signed(DW'(pxw[P-1:0])) <<< FRACTION_BITS;
  assign py  = $signed(DW'(pyw[P-1:0])) <<< FRACTION_BITS;
  assign x0  = DW'(in_data_i.seg_start_x);
  assign y0  = DW'(in_data_i.seg_start_y);
  assign x1  = DW'(in_data_i.seg_end_x);
  assign y1  = DW'(in_data_i.seg_end_y);

  assign in_ready_o = ((4'(qstat_i.count) + 4'(v1_q) + 4'(v2_q)) < 4'(QueueDepth));
  assign accept     = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    last1_q <= in_data_i.last_segment;
    wx_q    <= px - x0;
    wy_q    <= py - y0;
    vx_q    <= px - x1;
    vy_q    <= py - y1;
    ex_q    <= x1 - x0;
    ey_q    <= y1 - y0;
    last2_q <= last1_q;
    exwx_q  <= ex_q * wx_q;
    eywy_q  <= ey_q * wy_q;
    exex_q  <= ex_q * ex_q;
    eyey_q  <= ey_q * ey_q;
    exwy_q  <= ex_q * wy_q;
    eywx_q  <= ey_q * wx_q;
    wxwx_q  <= wx_q * wx_q;
    wywy_q  <= wy_q * wy_q;
    vxvx_q  <= vx_q * vx_q;
    vyvy_q  <= vy_q * vy_q;
  end

  always_comb begin
    dot      = SW'(exwx_q) + SW'(eywy_q);
    d2       = SW'(exex_q) + SW'(eyey_q);
    perp     = SW'(exwy_q) - SW'(eywx_q);
    perp_abs = perp[SW-1] ? $unsigned(-perp) : $unsigned(perp);
    w2       = $unsigned(SW'(wxwx_q) + SW'(wywy_q));
    v2       = $unsigned(SW'(vxvx_q) + SW'(vyvy_q));
    if (dot <= 0) begin
      kind  = KIND_DIRECT;
      value = w2;
    end else if (dot >= d2) begin
      kind  = KIND_DIRECT;
      value = v2;
    end else begin
      kind  = KIND_DIVIDE;
      value = perp_abs;
    end
  end

  assign push_o      = v2_q;
  assign push_data_o = {kind, last2_q, value, $unsigned(d2)};

endmodule

### rtl/core/sdf_queue.sv
// Short queue of classified entries between the front end and the back end.
// Depends on sdf_pkg for its depth and status type.
module sdf_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output sdf_pkg::qstat_t  qstat_o
);
  import sdf_pkg::*;

  localparam int unsigned AW = $clog2(QueueDepth);

  logic [WIDTH-1:0]      mem_q [QueueDepth];
  logic [AW-1:0]         wp_q, rp_q;
  logic [CountWidth-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= rp_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

  assign pop_data_o    = mem_q[rp_q];
  assign qstat_o.count = count_q;
  assign qstat_o.empty = (count_q == '0);

endmodule

### rtl/core/sdf_back.sv
// Back end: divides for the perpendicular case, keeps the running minimum,
// scales and takes the square root. Depends on sdf_pkg; pops from sdf_queue.
module sdf_back #(
  parameter int unsigned PIXEL_COORD_BITS = sdf_pkg::PixelCoordBits,
  parameter int unsigned FRACTION_BITS    = sdf_pkg::FractionBits,
  localparam int unsigned SW = sdf_pkg::sum_width(PIXEL_COORD_BITS, FRACTION_BITS),
  localparam int unsigned EW = 2 * SW + 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_wdata_i,
  input  sdf_pkg::qstat_t  qstat_i,
  output logic             pop_o,
  input  logic [EW-1:0]    pop_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_code_o
);
  import sdf_pkg::*;

  localparam int unsigned QW   = SW - 1;
  localparam int unsigned HW   = (SW + 1) / 2;
  localparam int unsigned LW   = SW - HW;
  localparam int unsigned NW   = 2 * SW;
  localparam int unsigned CW   = $clog2(QW + 1);
  localparam int unsigned MW   = MinWidth;
  localparam int unsigned HALF = MW / 2;
  localparam int unsigned GW   = 16;
  localparam int unsigned RW   = GW + MW;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PMUL,
    ST_PSUM,
    ST_DIV,
    ST_UPD,
    ST_GMUL,
    ST_GSUM,
    ST_SQRT,
    ST_EMIT
  } state_e;

  state_e             state_q;
  logic               last_q;
  logic [SW-1:0]      val_q, d2_q, rem_q;
  logic [2*HW-1:0]    ll_q;
  logic [HW+LW-1:0]   hl_q;
  logic [2*LW-1:0]    hh_q;
  logic [QW-1:0]      nlo_q, quo_q;
  logic [CW-1:0]      cnt_q;
  logic [MW-1:0]      min_q, mfin_q;
  logic [GW-1:0]      gsq_q;
  logic [GW+HALF-1:0] p1_q, p0_q;
  logic [RW-1:0]      rad_q, res_q, bit_q;
  logic               out_valid_q;
  logic [7:0]         out_code_q;

  logic [NW-1:0]      num;
  logic [SW:0]        r2, rdiff;
  logic               ge;
  logic [MW-1:0]      sat_dist, new_min;
  logic [RW-1:0]      trial, root;
  logic               sq_ge;
  logic [7:0]         code;

  assign pop_o = (state_q == ST_IDLE) && !qstat_i.empty;

  always_comb begin
    num      = (NW'(hh_q) << (2 * HW)) + (NW'(hl_q) << (HW + 1)) + NW'(ll_q);
    r2       = {rem_q, nlo_q[QW-1]};
    rdiff    = r2 - {1'b0, d2_q};
    ge       = (r2 >= {1'b0, d2_q});
    sat_dist = (val_q > {MW{1'b1}}) ? {MW{1'b1}} : MW'(val_q);
    new_min  = (sat_dist < min_q) ? sat_dist : min_q;
    trial    = res_q + bit_q;
    sq_ge    = (rad_q >= trial);
    root     = res_q >> FRACTION_BITS;
    code     = (root > RW'(255)) ? 8'hFF : root[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= 1'b0;
      val_q       <= '0;
      d2_q        <= '0;
      rem_q       <= '0;
      ll_q        <= '0;
      hl_q        <= '0;
      hh_q        <= '0;
      nlo_q       <= '0;
      quo_q       <= '0;
      cnt_q       <= '0;
      min_q       <= '1;
      mfin_q      <= '1;
      gsq_q       <= GW'(GainReset) * GW'(GainReset);
      p1_q        <= '0;
      p0_q        <= '0;
      rad_q       <= '0;
      res_q       <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
      out_code_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        gsq_q <= GW'(cfg_wdata_i) * GW'(cfg_wdata_i);
      end
      if (out_valid_q && out_ready_i && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            last_q  <= pop_data_i[EW-2];
            val_q   <= pop_data_i[2*SW-1:SW];
            d2_q    <= pop_data_i[SW-1:0];
            state_q <= (kind_e'(pop_data_i[EW-1]) == KIND_DIVIDE) ? ST_PMUL : ST_UPD;
          end
        end
        ST_PMUL: begin
          ll_q    <= val_q[HW-1:0] * val_q[HW-1:0];
          hl_q    <= val_q[SW-1:HW] * val_q[HW-1:0];
          hh_q    <= val_q[SW-1:HW] * val_q[SW-1:HW];
          state_q <= ST_PSUM;
        end
        ST_PSUM: begin
          rem_q   <= SW'(num >> QW);
          nlo_q   <= num[QW-1:0];
          quo_q   <= '0;
          cnt_q   <= CW'(QW);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q <= ge ? rdiff[SW-1:0] : r2[SW-1:0];
          nlo_q <= nlo_q << 1;
          quo_q <= {quo_q[QW-2:0], ge};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CW'(1)) begin
            val_q   <= SW'({quo_q[QW-2:0], ge});
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (last_q) begin
            mfin_q  <= new_min;
            min_q   <= '1;
            state_q <= ST_GMUL;
          end else begin
            min_q   <= new_min;
            state_q <= ST_IDLE;
          end
        end
        ST_GMUL: begin
          p1_q    <= gsq_q * mfin_q[MW-1:HALF];
          p0_q    <= gsq_q * mfin_q[HALF-1:0];
          state_q <= ST_GSUM;
        end
        ST_GSUM: begin
          rad_q   <= (RW'(p1_q) << HALF) + RW'(p0_q);
          res_q   <= '0;
          bit_q   <= RW'(1) << (RW - 2);
          state_q <= ST_SQRT;
        end
        ST_SQRT: begin
          if (sq_ge) begin
            rad_q <= rad_q - trial;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q == RW'(1)) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_code_q  <= code;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_code_o  = out_code_q;

endmodule

### rtl/core/segment_distance_field_pixel_unit.sv
// Top level of the segment distance field unit: front end, queue and back end.
// Depends on sdf_pkg, sdf_in_if, sdf_out_if, sdf_front, sdf_queue and sdf_back.
//
// Each request on in_i pairs one pixel with one outline segment. The unit finds
// the squared distance from the pixel to the segment and keeps the least one
// seen for the current pixel. A request with last_segment set closes the pixel:
// one result leaves on out_o with floor(gain * distance) clamped to 0..255, and
// the minimum starts over. Other requests give no result.
// The gain is written through cfg_we_i and cfg_wdata_i; it resets to 4.
// The front end takes a request every cycle while the four-entry queue has room
// and registers the differences, then the products, before classifying it. The
// back end takes one queue entry at a time: an entry whose nearest point is an
// endpoint goes straight to the minimum update, a perpendicular one first through
// the partial products, their sum and the one-bit-per-cycle divider. A closing
// request then goes through scaling by the squared gain and the 28-step square
// root. Results sit in an output register; while the receiver stalls the back end
// holds its next result and the queue fills, then in_i drops ready. Reset empties
// the queue, sets the minimum to all ones and the gain to 4.
module segment_distance_field_pixel_unit #(
  parameter int unsigned PIXEL_COORD_BITS = sdf_pkg::PixelCoordBits,
  parameter int unsigned FRACTION_BITS    = sdf_pkg::FractionBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  sdf_in_if.sink     in_i,
  sdf_out_if.source  out_o
);
  import sdf_pkg::*;

  localparam int unsigned SW = sum_width(PIXEL_COORD_BITS, FRACTION_BITS);
  localparam int unsigned EW = 2 * SW + 2;

  logic          push, pop;
  logic [EW-1:0] push_data, pop_data;
  qstat_t        qstat;

  sdf_front #(
    .PIXEL_COORD_BITS(PIXEL_COORD_BITS),
    .FRACTION_BITS   (FRACTION_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_data_i  (in_i.data),
    .qstat_i    (qstat),
    .push_o     (push),
    .push_data_o(push_data)
  );

  sdf_queue #(
    .WIDTH(EW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .qstat_o    (qstat)
  );

  sdf_back #(
    .PIXEL_COORD_BITS(PIXEL_COORD_BITS),
    .FRACTION_BITS   (FRACTION_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .qstat_i    (qstat),
    .pop_o      (pop),
    .pop_data_i (pop_data),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .out_code_o (out_o.data.distance_code)
  );

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.count <= CountWidth'(QueueDepth))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (qstat.count < CountWidth'(QueueDepth)))
    else $error("push into full queue");

endmodule

### tb/sv/segment_distance_field_pixel_unit_test.sv
// Testbench of the segment distance field pixel unit: directed and random
// pixel/segment requests, a scoreboard that predicts each distance code.
// Depends on sdf_pkg, sdf_in_if, sdf_out_if and the unit's RTL.
module segment_distance_field_pixel_unit_test;
  import sdf_pkg::*;

  localparam longint unsigned MinAllOnes = (64'd1 << 40) - 1;
  localparam int TimeoutCycles = 2000000;

  class distance_scoreboard;
    longint unsigned gain;
    longint unsigned least_dist;
    logic [7:0] expected_codes[$];
    int errors;
    int results_seen;

    function new();
      gain = 64'(GainReset);
      least_dist = MinAllOnes;
      errors = 0;
      results_seen = 0;
    endfunction

    function automatic longint unsigned sq_div(longint unsigned q, longint unsigned d);
      logic [127:0] prod;
      logic [127:0] rem;
      longint unsigned quo;
      prod = 128'(q) * 128'(q);
      rem = 0;
      quo = 0;
      for (int i = 127; i >= 0; i--) begin
        rem = {rem[126:0], prod[i]};
        quo = quo << 1;
        if (rem >= 128'(d)) begin
          rem = rem - 128'(d);
          quo = quo | 1;
        end
      end
      return quo;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function void note_request(in_req_t r);
      longint px, py, x0, y0, x1, y1, ex, ey, wx, wy, dot, d2, vx, vy, cr;
      longint unsigned sq_dist, root;
      logic [7:0] code;
      px = longint'(r.pixel_x) <<< FractionBits;
      py = longint'(r.pixel_y) <<< FractionBits;
      x0 = longint'(r.seg_start_x);
      y0 = longint'(r.seg_start_y);
      x1 = longint'(r.seg_end_x);
      y1 = longint'(r.seg_end_y);
      ex = x1 - x0;
      ey = y1 - y0;
      wx = px - x0;
      wy = py - y0;
      dot = ex * wx + ey * wy;
      d2 = ex * ex + ey * ey;
      if (dot <= 0) begin
        sq_dist = wx * wx + wy * wy;
      end else if (dot >= d2) begin
        vx = px - x1;
        vy = py - y1;
        sq_dist = vx * vx + vy * vy;
      end else begin
        cr = ex * wy - ey * wx;
        if (cr < 0) cr = -cr;
        sq_dist = sq_div(cr, d2);
      end
      if (sq_dist > MinAllOnes) sq_dist = MinAllOnes;
      if (sq_dist < least_dist) least_dist = sq_dist;
      if (r.last_segment) begin
        root = int_sqrt(gain * gain * least_dist) >> FractionBits;
        code = (root > 255) ? 8'd255 : root[7:0];
        expected_codes = {expected_codes, code};
        least_dist = MinAllOnes;
      end
    endfunction

    task check_result(out_req_t r);
      logic [7:0] want;
      results_seen++;
      if (expected_codes.size() == 0) begin
        report_mismatch($sformatf("unexpected result code %0d", r.distance_code));
        return;
      end
      want = expected_codes.pop_front();
      if (r.distance_code !== want)
        report_mismatch($sformatf("distance_code %0d, expected %0d", r.distance_code, want));
    endtask

    task report_mismatch(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [7:0] cfg_wdata_i = 0;
  sdf_in_if in_ch();
  sdf_out_if out_ch();
  distance_scoreboard board = new();
  int cycle_count = 0;
  int stall_hold = 0;
  int requests_sent = 0;
  bit stimulus_done = 0;

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
  end

  segment_distance_field_pixel_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TimeoutCycles) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 4);
    return 0;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) board.check_result(out_ch.data);
      if (stall_hold > 0) begin
        stall_hold <= stall_hold - 1;
        out_ch.ready <= 0;
      end else if (gap_len() != 0 && $urandom_range(0, 1) == 0) begin
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= 1;
      end
    end
  end

  task automatic send_request(in_req_t r);
    int gap;
    gap = gap_len();
    if (gap != 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1;
    in_ch.data <= r;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_request(r);
    requests_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 0;
    while (board.expected_codes.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_gain(logic [7:0] g);
    drain_results();
    cfg_we_i <= 1;
    cfg_wdata_i <= g;
    @(posedge clk_i);
    cfg_we_i <= 0;
    board.gain = 64'(g);
  endtask

  function automatic in_req_t make_request(bit last);
    in_req_t r;
    r.pixel_x = 10'($urandom);
    r.pixel_y = 10'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      r.seg_start_x = 16'($urandom);
      r.seg_start_y = 16'($urandom);
      r.seg_end_x = 16'($urandom);
      r.seg_end_y = 16'($urandom);
    end else begin
      r.seg_start_x = 16'((int'(r.pixel_x) << 4) + $signed($urandom_range(0, 800)) - 400);
      r.seg_start_y = 16'((int'(r.pixel_y) << 4) + $signed($urandom_range(0, 800)) - 400);
      r.seg_end_x = 16'((int'(r.pixel_x) << 4) + $signed($urandom_range(0, 800)) - 400);
      r.seg_end_y = 16'((int'(r.pixel_y) << 4) + $signed($urandom_range(0, 800)) - 400);
    end
    if ($urandom_range(0, 9) == 0) r.seg_end_x = r.seg_start_x;
    if ($urandom_range(0, 9) == 0) r.seg_end_y = r.seg_start_y;
    r.last_segment = last;
    return r;
  endfunction

  function automatic in_req_t directed(int px, int py, int sx, int sy, int ex, int ey, bit l);
    in_req_t r;
    r.pixel_x = 10'(px);
    r.pixel_y = 10'(py);
    r.seg_start_x = 16'(sx);
    r.seg_start_y = 16'(sy);
    r.seg_end_x = 16'(ex);
    r.seg_end_y = 16'(ey);
    r.last_segment = l;
    return r;
  endfunction

  initial begin
    int segs;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_request(directed(0, 0, 0, 0, 0, 0, 1));
    send_request(directed(1023, 1023, -32768, -32768, 32767, 32767, 1));
    send_request(directed(0, 1023, 32767, -32768, 32767, -32768, 1));
    send_request(directed(5, 5, 0, 0, 160, 0, 0));
    send_request(directed(5, 5, 100, 100, 100, 100, 1));
    send_request(directed(10, 10, 0, 0, 320, 320, 1));
    send_request(directed(3, 7, 0, 0, 16, 0, 1));
    send_request(directed(1023, 0, -32768, 32767, -32768, -32768, 1));
    send_request(directed(512, 512, 8200, 8000, 8100, 8300, 1));
    write_gain(8'd0);
    send_request(directed(100, 100, 0, 0, 0, 0, 1));
    send_request(directed(1, 2, 3, 4, 500, 600, 1));
    write_gain(8'd255);
    send_request(directed(0, 0, 16, 0, 16, 0, 1));
    send_request(directed(0, 0, 1, 1, 1, 1, 1));
    send_request(directed(300, 200, 4800, 3190, 4800, 3300, 1));
    write_gain(8'd1);
    send_request(directed(1023, 1023, 32767, 32767, -32768, 32767, 1));
    fork
      begin
        stall_hold = 400;
      end
      begin
        for (int i = 0; i < 12; i++) send_request(make_request($urandom_range(0, 1)));
      end
    join
    for (int phase = 0; phase < 4; phase++) begin
      write_gain(phase == 0 ? 8'd4 : phase == 1 ? 8'd255 : 8'($urandom_range(0, 255)));
      while (requests_sent < 220 * (phase + 1) + 20) begin
        segs = $urandom_range(1, 4);
        for (int s = 0; s < segs; s++) send_request(make_request(s == segs - 1));
      end
    end
    send_request(make_request(1));
    drain_results();
    $display("Sent %0d requests under several gain settings; %0d distance codes checked.",
             requests_sent, board.results_seen);
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
